/* rtl/nsc_pkg.sv */
`default_nettype none

package nsc_pkg;

	localparam int BYTE_W  = 8;
	localparam int LEN_W   = 7;
	localparam int HDR_W   = 48;
	localparam int HDR_LEN = 6;
	localparam int NREG    = 4;

	localparam logic [BYTE_W-1:0] NEWLINE = 8'h0A;
	localparam logic [BYTE_W-1:0] DOLLAR  = 8'h24;

	localparam logic [HDR_W-1:0] HDR_RESET [NREG] = '{
		48'h244750524D43,
		48'h244750474741,
		48'h244750475341,
		48'h2447504C4C4C
	};

	typedef enum logic [1:0] {
		ACT_BYTE  = 2'd0,
		ACT_REARM = 2'd1,
		ACT_READ  = 2'd2,
		ACT_IDLE  = 2'd3
	} act_t;

	localparam logic KIND_NOTICE = 1'b0;
	localparam logic KIND_READ   = 1'b1;

	// command broadcast from the top level to every channel
	typedef struct packed {
		logic              feed;
		logic              rearm;
		logic              rd;
		logic [BYTE_W-1:0] rx;
		logic [LEN_W-1:0]  rd_idx;
	} cmd_t;

	// per-channel status back to the top level
	typedef struct packed {
		logic             complete;
		logic             done_nxt;
		logic [LEN_W-1:0] len_nxt;
		logic [LEN_W-1:0] len_q;
	} stat_t;

endpackage

`default_nettype wire

/* rtl/nsc_ram.sv */
`default_nettype none

module nsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/nsc_channel.sv */
`default_nettype none

module nsc_channel
	import nsc_pkg::*;
#(
	parameter int MAX_LENGTH = 70,
	parameter int BODY_DEPTH = 128
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [HDR_W-1:0]  hdr,
	input  wire cmd_t              cmd,
	output stat_t                  stat,
	output logic      [BYTE_W-1:0] rd_data
);

	localparam int LIMIT = (MAX_LENGTH < BODY_DEPTH) ? MAX_LENGTH : BODY_DEPTH;
	localparam int DEPTH = 2 * BODY_DEPTH;
	localparam int AW    = $clog2(DEPTH);

	// two banks: one collects, the other holds the finished body
	logic [LEN_W-1:0] idx_q, idx_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic             done_q, done_d;
	logic             cap_bank_q, cap_bank_d;
	logic             body_bank_q, body_bank_d;

	logic [BYTE_W-1:0] hb_idx, hb0;
	logic              we;
	logic [LEN_W-1:0]  wpos;
	logic              complete;
	logic [AW-1:0]     waddr, raddr;

	always_comb begin
		hb_idx = '0;
		for (int k = 0; k < HDR_LEN; k++) begin
			if (idx_q == LEN_W'(k)) begin
				hb_idx = hdr[8*(HDR_LEN-1-k) +: 8];
			end
		end
		hb0 = hdr[HDR_W-1 -: 8];
	end

	always_comb begin
		idx_d       = idx_q;
		len_d       = len_q;
		done_d      = done_q;
		cap_bank_d  = cap_bank_q;
		body_bank_d = body_bank_q;
		we          = 1'b0;
		wpos        = idx_q;
		complete    = 1'b0;
		if (cmd.feed && !done_q) begin
			if (idx_q < LEN_W'(HDR_LEN) && cmd.rx == hb_idx) begin
				we    = 1'b1;
				idx_d = idx_q + 1'b1;
			end else if (idx_q >= LEN_W'(HDR_LEN) && cmd.rx == NEWLINE) begin
				complete    = 1'b1;
				len_d       = idx_q;
				idx_d       = '0;
				done_d      = 1'b1;
				body_bank_d = cap_bank_q;
				cap_bank_d  = !cap_bank_q;
			end else if (idx_q >= LEN_W'(HDR_LEN) && idx_q < LEN_W'(LIMIT)) begin
				we    = 1'b1;
				idx_d = idx_q + 1'b1;
			end else if (cmd.rx == hb0) begin
				// mismatch or overflow: retry byte as header start
				we    = 1'b1;
				wpos  = '0;
				idx_d = LEN_W'(1);
			end else begin
				idx_d = '0;
			end
		end
		if (cmd.rearm) begin
			done_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			len_q       <= '0;
			done_q      <= 1'b0;
			cap_bank_q  <= 1'b0;
			body_bank_q <= 1'b1;
		end else begin
			idx_q       <= idx_d;
			len_q       <= len_d;
			done_q      <= done_d;
			cap_bank_q  <= cap_bank_d;
			body_bank_q <= body_bank_d;
		end
	end

	assign waddr = AW'(cap_bank_q ? BODY_DEPTH : 0) + AW'(wpos);
	assign raddr = AW'(body_bank_q ? BODY_DEPTH : 0) + AW'(cmd.rd_idx);

	nsc_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(cmd.rx),
		.re   (cmd.rd),
		.raddr(raddr),
		.rdata(rd_data)
	);

	assign stat.complete = complete;
	assign stat.done_nxt = done_d;
	assign stat.len_nxt  = len_d;
	assign stat.len_q    = len_q;

endmodule

`default_nettype wire

/* rtl/nmea_sentence_capture_unit.sv */
// An accepted word lands in the input register, and its result is loaded into
// the result register when the output is free to advance.
// Throughput: one word per cycle; input stalls only while the input register
// and a result held back by out_ready are both occupied.
// Reset: arst_n clears control state and all done flags and reloads the
// header registers; the RAM contents are not cleared and no sweep runs.
`default_nettype none

module nmea_sentence_capture_unit
	import nsc_pkg::*;
#(
	parameter int MAX_LENGTH = 70,
	parameter int BODY_DEPTH = 128,
	parameter int CHANNELS   = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [1:0]        action,
	input  wire logic [BYTE_W-1:0] rx_byte,
	input  wire logic [1:0]        channel,
	input  wire logic [LEN_W-1:0]  read_index,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   kind,
	output logic      [1:0]        which_channel,
	output logic      [LEN_W-1:0]  sentence_length,
	output logic      [BYTE_W-1:0] data_byte,
	output logic                   all_done,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [HDR_W-1:0]  cfg_data
);

	localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic [HDR_W-1:0] hdr_q [NREG];

	logic              valid_s1;
	act_t              act_s1;
	logic [BYTE_W-1:0] rx_s1;
	logic [1:0]        ch_s1;
	logic [LEN_W-1:0]  ridx_s1;

	logic              valid_s2;
	logic              kind_s2;
	logic [1:0]        wch_s2;
	logic [LEN_W-1:0]  len_s2;
	logic              zero_s2;
	logic [CW-1:0]     rsel_s2;
	logic              all_done_s2;

	logic              advance;
	cmd_t              cmd;
	stat_t             stat    [CHANNELS];
	logic [BYTE_W-1:0] rd_data [CHANNELS];
	logic [CHANNELS-1:0] done_nxt;

	logic              any_cmp;
	logic [CW-1:0]     first;
	logic              rch_ok;
	logic [CW-1:0]     rsel;
	logic [LEN_W-1:0]  len_rd;
	logic              res_valid;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NREG; i++) begin
				hdr_q[i] <= HDR_RESET[i];
			end
		end else if (cfg_valid) begin
			hdr_q[cfg_index] <= cfg_data;
		end
	end

	assign advance  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			act_s1  <= act_t'(action);
			rx_s1   <= rx_byte;
			ch_s1   <= channel;
			ridx_s1 <= read_index;
		end
	end

	always_comb begin
		cmd.feed   = valid_s1 && advance && act_s1 == ACT_BYTE;
		cmd.rearm  = valid_s1 && advance && act_s1 == ACT_REARM;
		cmd.rd     = valid_s1 && advance && act_s1 == ACT_READ;
		cmd.rx     = rx_s1;
		cmd.rd_idx = ridx_s1;
	end

	for (genvar c = 0; c < CHANNELS; c++) begin : g_ch
		logic [HDR_W-1:0] hdr_c;
		if (c < NREG) begin : g_reg
			assign hdr_c = hdr_q[c];
		end else begin : g_zero
			assign hdr_c = '0;
		end

		nsc_channel #(
			.MAX_LENGTH(MAX_LENGTH),
			.BODY_DEPTH(BODY_DEPTH)
		) u_channel (
			.clk    (clk),
			.arst_n (arst_n),
			.hdr    (hdr_c),
			.cmd    (cmd),
			.stat   (stat[c]),
			.rd_data(rd_data[c])
		);

		assign done_nxt[c] = stat[c].done_nxt;
	end

	always_comb begin
		any_cmp = 1'b0;
		first   = '0;
		for (int c = CHANNELS - 1; c >= 0; c--) begin
			if (stat[c].complete) begin
				any_cmp = 1'b1;
				first   = CW'(c);
			end
		end
	end

	assign rch_ok = 4'(ch_s1) < 4'(CHANNELS);
	assign rsel   = CW'(ch_s1);
	assign len_rd = rch_ok ? stat[rsel].len_q : '0;

	assign res_valid = valid_s1 &&
		((act_s1 == ACT_BYTE && any_cmp) || act_s1 == ACT_READ);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			all_done_s2 <= &done_nxt;
			rsel_s2     <= rsel;
			if (act_s1 == ACT_READ) begin
				kind_s2 <= KIND_READ;
				wch_s2  <= ch_s1;
				len_s2  <= len_rd;
				zero_s2 <= !rch_ok || ridx_s1 >= len_rd;
			end else begin
				kind_s2 <= KIND_NOTICE;
				wch_s2  <= 2'(first);
				len_s2  <= stat[first].len_nxt;
				zero_s2 <= 1'b1;
			end
		end
	end

	assign out_valid       = valid_s2;
	assign kind            = kind_s2;
	assign which_channel   = wch_s2;
	assign sentence_length = len_s2;
	assign data_byte       = zero_s2 ? '0 : rd_data[rsel_s2];
	assign all_done        = all_done_s2;

endmodule

`default_nettype wire

/* rtl/nsc_checker.sv */
`default_nettype none

module nsc_checker
	import nsc_pkg::*;
#(
	parameter int MAX_LENGTH = 70
) (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic              kind,
	input wire logic [1:0]        which_channel,
	input wire logic [LEN_W-1:0]  sentence_length,
	input wire logic [BYTE_W-1:0] data_byte,
	input wire logic              all_done
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(kind) && $stable(which_channel) &&
			$stable(sentence_length) && $stable(data_byte) && $stable(all_done))
		else $error("result changed while stalled");

	a_notice_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_NOTICE |-> data_byte == '0)
		else $error("notice carries data");

	a_notice_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_NOTICE |->
			sentence_length >= LEN_W'(HDR_LEN) && sentence_length <= LEN_W'(MAX_LENGTH))
		else $error("notice length out of range");

	a_read_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_READ && data_byte != '0 |-> sentence_length != '0)
		else $error("read data from empty body");

endmodule

bind nmea_sentence_capture_unit nsc_checker #(.MAX_LENGTH(MAX_LENGTH)) u_nsc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.kind           (kind),
	.which_channel  (which_channel),
	.sentence_length(sentence_length),
	.data_byte      (data_byte),
	.all_done       (all_done)
);

`default_nettype wire
